@@ src/cgia_pkg.sv @@
// Shared widths, register indexes, layout codes and the config struct
// for the column-group interleave address generator. No dependencies.
package cgia_pkg;

    localparam int ROW_W       = 12;
    localparam int COL_W       = 12;
    localparam int VAL_W       = 32;
    localparam int DEST_W      = 25;
    localparam int CNT_W       = 13;
    localparam int LOG_W       = 3;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int OFS_W       = 4;

    localparam int MAX_GROUP_LOG = 4;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_LOG   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LAYOUT_MODE = 2'd3;

    localparam logic [MODE_W-1:0] MODE_PLAIN     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPHERICAL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TRIANGLE  = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0]  row_count;
        logic [CNT_W-1:0]  col_count;
        logic [LOG_W-1:0]  group_log;   // already clamped to 1..MAX_GROUP_LOG
        logic [MODE_W-1:0] layout_mode;
    } cfg_t;

    typedef struct packed {
        logic [DEST_W-1:0] dest_index;
        logic              bad_coord;
    } map_t;

endpackage

@@ src/cgia_cfg.sv @@
// Configuration register file for the interleave address generator.
// Depends on cgia_pkg.
module cgia_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cgia_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cgia_pkg::CFG_DATA_W-1:0]   cfg_data,
    output cgia_pkg::cfg_t                    cfg
);

    cgia_pkg::cfg_t                cfg_reg;
    logic [cgia_pkg::LOG_W-1:0]    log_raw;
    logic [cgia_pkg::LOG_W-1:0]    log_clamped;

    assign log_raw = cfg_data[cgia_pkg::LOG_W-1:0];

    always_comb
    begin
        priority if (log_raw == '0)
            log_clamped = cgia_pkg::LOG_W'(1);
        else if (log_raw > cgia_pkg::LOG_W'(cgia_pkg::MAX_GROUP_LOG))
            log_clamped = cgia_pkg::LOG_W'(cgia_pkg::MAX_GROUP_LOG);
        else
            log_clamped = log_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_count   <= cgia_pkg::CNT_W'(1);
            cfg_reg.col_count   <= cgia_pkg::CNT_W'(1);
            cfg_reg.group_log   <= cgia_pkg::LOG_W'(1);
            cfg_reg.layout_mode <= cgia_pkg::MODE_PLAIN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cgia_pkg::REG_ROW_COUNT:   cfg_reg.row_count <= cfg_data;
                cgia_pkg::REG_COL_COUNT:   cfg_reg.col_count <= cfg_data;
                cgia_pkg::REG_GROUP_LOG:   cfg_reg.group_log <= log_clamped;
                cgia_pkg::REG_LAYOUT_MODE:
                    cfg_reg.layout_mode <= cfg_data[cgia_pkg::MODE_W-1:0];
                default:                   cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/cgia_map.sv @@
// Combinational address map: picks the group (base column, width) for a
// coordinate and forms the interleaved index. Depends on cgia_pkg.
module cgia_map (
    input  cgia_pkg::cfg_t                 cfg,
    input  logic [cgia_pkg::ROW_W-1:0]     row,
    input  logic [cgia_pkg::COL_W-1:0]     column,
    output cgia_pkg::map_t                 result
);

    logic [cgia_pkg::COL_W-1:0]   sel_base;
    logic [cgia_pkg::LOG_W-1:0]   sel_log;
    logic                         hit;
    logic                         copy_col;
    logic [cgia_pkg::CNT_W-1:0]   lead_cols;
    logic [cgia_pkg::COL_W-1:0]   width_mask;
    logic [cgia_pkg::COL_W-1:0]   start_col;
    logic [cgia_pkg::OFS_W-1:0]   offset;
    logic [cgia_pkg::DEST_W-1:0]  start_term;
    logic [cgia_pkg::DEST_W-1:0]  row_term;
    logic [cgia_pkg::DEST_W-1:0]  index;
    logic                         bad;
    logic                         peel_mode;

    assign peel_mode = (cfg.layout_mode == cgia_pkg::MODE_SPHERICAL) ||
                       (cfg.layout_mode == cgia_pkg::MODE_TRIANGLE);

    // Leading M mod 2L columns are split off level by level; the widest
    // level whose leading block the column clears wins.
    always_comb
    begin
        hit       = 1'b0;
        sel_base  = '0;
        sel_log   = cfg.group_log;
        lead_cols = '0;
        for (int k = 2; k <= cgia_pkg::MAX_GROUP_LOG; k++)
        begin
            lead_cols = cfg.col_count & ((cgia_pkg::CNT_W'(1) << (k + 1)) -
                                         cgia_pkg::CNT_W'(1));
            if ((cgia_pkg::LOG_W'(k) <= cfg.group_log) &&
                ({1'b0, column} >= lead_cols))
            begin
                hit      = 1'b1;
                sel_base = lead_cols[cgia_pkg::COL_W-1:0];
                sel_log  = cgia_pkg::LOG_W'(k);
            end
        end
        if (!peel_mode)
        begin
            sel_base = '0;
            sel_log  = cfg.group_log;
        end
        else if (!hit)
        begin
            sel_log  = cgia_pkg::LOG_W'(1);
            sel_base = (cfg.layout_mode == cgia_pkg::MODE_SPHERICAL) ?
                       cgia_pkg::COL_W'(1) : '0;
        end
    end

    assign copy_col = peel_mode && !hit &&
                      (cfg.layout_mode == cgia_pkg::MODE_SPHERICAL) &&
                      (column == '0);

    assign width_mask = ~((cgia_pkg::COL_W'(1) << sel_log) - cgia_pkg::COL_W'(1));
    assign start_col  = sel_base + ((column - sel_base) & width_mask);
    assign offset     = cgia_pkg::OFS_W'(column - start_col);

    assign start_term = cgia_pkg::DEST_W'(start_col) * cgia_pkg::DEST_W'(cfg.row_count);
    assign row_term   = cgia_pkg::DEST_W'({row, {cgia_pkg::OFS_W{1'b0}}} >>
                                          (cgia_pkg::OFS_W - 32'(sel_log)));
    assign index      = copy_col ? cgia_pkg::DEST_W'(row) :
                        start_term + row_term + cgia_pkg::DEST_W'(offset);

    assign bad = ({1'b0, row} >= cfg.row_count) || ({1'b0, column} >= cfg.col_count);

    assign result.dest_index = bad ? '0 : index;
    assign result.bad_coord  = bad;

endmodule

@@ src/column_group_interleave_address.sv @@
// Top level of the column-group interleave address generator: config
// registers, input word register, address map and result register.
// Depends on cgia_pkg, cgia_cfg and cgia_map.
//
//   channel  | handshake                  | word
//   ---------+----------------------------+-------------------------------
//   item     | item_valid / item_stall    | row, column, value
//   result   | result_valid / result_stall| dest_index, value_out, bad_coord
//   config   | cfg_we (no wait)           | cfg_index, cfg_data
//
// One word per cycle sustained while result_stall is low; an accepted word
// goes into the input register, then through the map and 12x13 multiply
// into the result register, from which its result can be taken.
// Reset clears both stage valids and returns the registers to N=M=1,
// L=2, plain layout. result_stall holds the result register; the input
// register takes words while it is empty or the result register can move.
module column_group_interleave_address (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cgia_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cgia_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [cgia_pkg::ROW_W-1:0]        row,
    input  logic [cgia_pkg::COL_W-1:0]        column,
    input  logic [cgia_pkg::VAL_W-1:0]        value,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [cgia_pkg::DEST_W-1:0]       dest_index,
    output logic [cgia_pkg::VAL_W-1:0]        value_out,
    output logic                              bad_coord
);

    cgia_pkg::cfg_t                 cfg;
    cgia_pkg::map_t                 map_res;

    logic                           in_valid_reg;
    logic [cgia_pkg::ROW_W-1:0]     row_reg;
    logic [cgia_pkg::COL_W-1:0]     col_reg;
    logic [cgia_pkg::VAL_W-1:0]     val_reg;

    logic                           out_valid_reg;
    logic [cgia_pkg::DEST_W-1:0]    dest_reg;
    logic [cgia_pkg::VAL_W-1:0]     vout_reg;
    logic                           bad_reg;

    logic                           out_move;
    logic                           in_move;

    cgia_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cgia_map u_map (
        .cfg    (cfg),
        .row    (row_reg),
        .column (col_reg),
        .result (map_res)
    );

    assign out_move   = !out_valid_reg || !result_stall;
    assign in_move    = !in_valid_reg || out_move;
    assign item_stall = !in_move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_move)
                in_valid_reg <= item_valid;
            if (out_move)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_move && item_valid)
        begin
            row_reg <= row;
            col_reg <= column;
            val_reg <= value;
        end
        if (out_move && in_valid_reg)
        begin
            dest_reg <= map_res.dest_index;
            bad_reg  <= map_res.bad_coord;
            vout_reg <= val_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign dest_index   = dest_reg;
    assign value_out    = vout_reg;
    assign bad_coord    = bad_reg;

endmodule
